// ===== src/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared widths, types and state codes for the coordinate deviation core.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int COORD_BITS  = 12;

    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_N       = $clog2(MAX_SAMPLES);
    localparam int SUM_W       = COORD_BITS + LOG_N;
    localparam int XSQ_W       = 2 * COORD_BITS;
    localparam int SQ_W        = XSQ_W + LOG_N;
    localparam int PROD_W      = CNT_W + SQ_W;
    localparam int SCALE_SHIFT = 8;
    localparam int ROOT_W      = (PROD_W + SCALE_SHIFT + 1) / 2;
    localparam int V2_W        = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int ALU_W       = (PROD_W > REM_W) ? PROD_W : REM_W;
    localparam int DEV_W       = 16;
    localparam int QUO_W       = (ROOT_W > DEV_W) ? ROOT_W : DEV_W;
    localparam int ITER_AB     = (SUM_W > CNT_W) ? SUM_W : CNT_W;
    localparam int MAX_ITER    = (ITER_AB > ROOT_W) ? ITER_AB : ROOT_W;
    localparam int IDX_W       = $clog2(MAX_ITER);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_DIFF,
        S_SQRT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SQ_W-1:0]  sq_x;
        logic [SQ_W-1:0]  sq_y;
        logic             dropped;
    } t_acc;

endpackage

// ===== src/csd_addsub.sv =====
// ----------------------------------------------------------------------------
// csd_addsub
// Shared adder/subtractor used by every step of the deviation sequencer.
// ----------------------------------------------------------------------------
module csd_addsub (
    input  csd_pkg::t_alu_op           i_op,
    input  logic [csd_pkg::ALU_W-1:0]  i_a,
    input  logic [csd_pkg::ALU_W-1:0]  i_b,
    output logic [csd_pkg::ALU_W-1:0]  o_result,
    output logic                       o_borrow
);

    logic [csd_pkg::ALU_W-1:0] operand_b;
    logic                      carry_in;
    logic [csd_pkg::ALU_W:0]   total;

    always_comb begin
        case (i_op)
            csd_pkg::ALU_ADD: begin
                operand_b = i_b;
                carry_in  = 1'b0;
            end
            csd_pkg::ALU_SUB: begin
                operand_b = ~i_b;
                carry_in  = 1'b1;
            end
            default: begin
                operand_b = i_b;
                carry_in  = 1'b0;
            end
        endcase
    end

    assign total    = {1'b0, i_a} + {1'b0, operand_b} + {{csd_pkg::ALU_W{1'b0}}, carry_in};
    assign o_result = total[csd_pkg::ALU_W-1:0];
    assign o_borrow = (i_op == csd_pkg::ALU_SUB) && !total[csd_pkg::ALU_W];

endmodule

// ===== src/csd_accum.sv =====
// ----------------------------------------------------------------------------
// csd_accum
// Sample counter with running sums and sums of squares for both axes.
// ----------------------------------------------------------------------------
module csd_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_add,
    input  logic                           i_clear,
    input  logic [csd_pkg::COORD_BITS-1:0] i_x,
    input  logic [csd_pkg::COORD_BITS-1:0] i_y,
    output csd_pkg::t_acc                  o_acc
);

    csd_pkg::t_acc             r_acc;
    csd_pkg::t_acc             n_acc;
    logic [csd_pkg::XSQ_W-1:0] x_sq;
    logic [csd_pkg::XSQ_W-1:0] y_sq;
    logic                      full;

    assign x_sq = csd_pkg::XSQ_W'(i_x) * csd_pkg::XSQ_W'(i_x);
    assign y_sq = csd_pkg::XSQ_W'(i_y) * csd_pkg::XSQ_W'(i_y);
    assign full = (r_acc.count >= csd_pkg::CNT_W'(csd_pkg::MAX_SAMPLES));

    always_comb begin
        n_acc = r_acc;
        if (i_clear) begin
            n_acc = '0;
        end else if (i_add) begin
            if (full) begin
                n_acc.dropped = 1'b1;
            end else begin
                n_acc.count = r_acc.count + csd_pkg::CNT_W'(1);
                n_acc.sum_x = r_acc.sum_x + csd_pkg::SUM_W'(i_x);
                n_acc.sum_y = r_acc.sum_y + csd_pkg::SUM_W'(i_y);
                n_acc.sq_x  = r_acc.sq_x + csd_pkg::SQ_W'(x_sq);
                n_acc.sq_y  = r_acc.sq_y + csd_pkg::SQ_W'(y_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== src/csd_engine.sv =====
// ----------------------------------------------------------------------------
// csd_engine
// Sequencer that computes both deviations with one shared adder/subtractor:
// shift-add products, a bit-pair square root and a restoring divide.
// ----------------------------------------------------------------------------
module csd_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  csd_pkg::t_acc             i_acc,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [csd_pkg::CNT_W-1:0] o_sample_count,
    output logic [csd_pkg::DEV_W-1:0] o_x_deviation,
    output logic [csd_pkg::DEV_W-1:0] o_y_deviation,
    output logic                      o_no_samples,
    output logic                      o_samples_dropped
);

    csd_pkg::t_state              r_state;
    csd_pkg::t_state              n_state;
    csd_pkg::t_acc                r_snap;
    csd_pkg::t_acc                n_snap;
    logic                         r_axis;
    logic                         n_axis;
    logic [csd_pkg::IDX_W-1:0]    r_idx;
    logic [csd_pkg::IDX_W-1:0]    n_idx;
    logic [csd_pkg::ALU_W-1:0]    r_acc;
    logic [csd_pkg::ALU_W-1:0]    n_acc;
    logic [csd_pkg::PROD_W-1:0]   r_a;
    logic [csd_pkg::PROD_W-1:0]   n_a;
    logic [csd_pkg::PROD_W-1:0]   r_mcand;
    logic [csd_pkg::PROD_W-1:0]   n_mcand;
    logic [csd_pkg::SUM_W-1:0]    r_mplier;
    logic [csd_pkg::SUM_W-1:0]    n_mplier;
    logic [csd_pkg::V2_W-1:0]     r_v;
    logic [csd_pkg::V2_W-1:0]     n_v;
    logic [csd_pkg::REM_W-1:0]    r_rem;
    logic [csd_pkg::REM_W-1:0]    n_rem;
    logic [csd_pkg::ROOT_W-1:0]   r_root;
    logic [csd_pkg::ROOT_W-1:0]   n_root;
    logic [csd_pkg::QUO_W-1:0]    r_quo;
    logic [csd_pkg::QUO_W-1:0]    n_quo;
    logic [csd_pkg::DEV_W-1:0]    r_xdev;
    logic [csd_pkg::DEV_W-1:0]    n_xdev;
    logic [csd_pkg::DEV_W-1:0]    r_ydev;
    logic [csd_pkg::DEV_W-1:0]    n_ydev;

    csd_pkg::t_alu_op             alu_op;
    logic [csd_pkg::ALU_W-1:0]    alu_a;
    logic [csd_pkg::ALU_W-1:0]    alu_b;
    logic [csd_pkg::ALU_W-1:0]    alu_result;
    logic                         alu_borrow;

    logic [csd_pkg::SUM_W-1:0]    cur_sum;
    logic [csd_pkg::PROD_W-1:0]   diff;
    logic [csd_pkg::REM_W-1:0]    rem_shift;
    logic [csd_pkg::REM_W-1:0]    trial;
    logic [csd_pkg::CNT_W:0]      partial;
    logic                         last_a;
    logic                         last_b;
    logic                         last_root;
    logic                         empty_in;

    csd_addsub u_addsub (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_result (alu_result),
        .o_borrow (alu_borrow)
    );

    assign cur_sum   = r_axis ? r_snap.sum_y : r_snap.sum_x;
    assign last_a    = (r_idx == csd_pkg::IDX_W'(csd_pkg::CNT_W - 1));
    assign last_b    = (r_idx == csd_pkg::IDX_W'(csd_pkg::SUM_W - 1));
    assign last_root = (r_idx == csd_pkg::IDX_W'(csd_pkg::ROOT_W - 1));
    assign empty_in  = (i_acc.count == '0);
    assign diff      = alu_borrow ? '0 : alu_result[csd_pkg::PROD_W-1:0];
    assign rem_shift = {r_rem[csd_pkg::REM_W-3:0], r_v[csd_pkg::V2_W-1 -: 2]};
    assign trial     = {r_root, 2'b01};
    assign partial   = {r_rem[csd_pkg::CNT_W-1:0], r_root[csd_pkg::ROOT_W-1]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            csd_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = empty_in ? csd_pkg::S_DONE : csd_pkg::S_MUL_A;
                end
            end
            csd_pkg::S_MUL_A: begin
                if (last_a) begin
                    n_state = csd_pkg::S_MUL_B;
                end
            end
            csd_pkg::S_MUL_B: begin
                if (last_b) begin
                    n_state = csd_pkg::S_DIFF;
                end
            end
            csd_pkg::S_DIFF: begin
                n_state = csd_pkg::S_SQRT;
            end
            csd_pkg::S_SQRT: begin
                if (last_root) begin
                    n_state = csd_pkg::S_DIV;
                end
            end
            csd_pkg::S_DIV: begin
                if (last_root) begin
                    n_state = r_axis ? csd_pkg::S_DONE : csd_pkg::S_MUL_A;
                end
            end
            csd_pkg::S_DONE: begin
                n_state = csd_pkg::S_IDLE;
            end
            default: begin
                n_state = csd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_snap   = r_snap;
        n_axis   = r_axis;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_a      = r_a;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_v      = r_v;
        n_rem    = r_rem;
        n_root   = r_root;
        n_quo    = r_quo;
        n_xdev   = r_xdev;
        n_ydev   = r_ydev;
        alu_op   = csd_pkg::ALU_ADD;
        alu_a    = '0;
        alu_b    = '0;
        case (r_state)
            csd_pkg::S_IDLE: begin
                if (i_start) begin
                    n_snap   = i_acc;
                    n_axis   = 1'b0;
                    n_idx    = '0;
                    n_acc    = '0;
                    n_mcand  = csd_pkg::PROD_W'(i_acc.sq_x);
                    n_mplier = csd_pkg::SUM_W'(i_acc.count);
                    n_xdev   = '0;
                    n_ydev   = '0;
                end
            end
            csd_pkg::S_MUL_A, csd_pkg::S_MUL_B: begin
                alu_op   = csd_pkg::ALU_ADD;
                alu_a    = r_acc;
                alu_b    = r_mplier[0] ? csd_pkg::ALU_W'(r_mcand) : '0;
                n_acc    = alu_result;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_idx    = r_idx + csd_pkg::IDX_W'(1);
                if ((r_state == csd_pkg::S_MUL_A) && last_a) begin
                    n_a      = alu_result[csd_pkg::PROD_W-1:0];
                    n_acc    = '0;
                    n_mcand  = csd_pkg::PROD_W'(cur_sum);
                    n_mplier = cur_sum;
                    n_idx    = '0;
                end
                if ((r_state == csd_pkg::S_MUL_B) && last_b) begin
                    n_idx = '0;
                end
            end
            csd_pkg::S_DIFF: begin
                alu_op = csd_pkg::ALU_SUB;
                alu_a  = csd_pkg::ALU_W'(r_a);
                alu_b  = r_acc;
                n_v    = csd_pkg::V2_W'({diff, {csd_pkg::SCALE_SHIFT{1'b0}}});
                n_rem  = '0;
                n_root = '0;
                n_idx  = '0;
            end
            csd_pkg::S_SQRT: begin
                alu_op = csd_pkg::ALU_SUB;
                alu_a  = csd_pkg::ALU_W'(rem_shift);
                alu_b  = csd_pkg::ALU_W'(trial);
                n_v    = r_v << 2;
                n_idx  = r_idx + csd_pkg::IDX_W'(1);
                if (!alu_borrow) begin
                    n_rem  = alu_result[csd_pkg::REM_W-1:0];
                    n_root = {r_root[csd_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_shift;
                    n_root = {r_root[csd_pkg::ROOT_W-2:0], 1'b0};
                end
                if (last_root) begin
                    n_rem = '0;
                    n_quo = '0;
                    n_idx = '0;
                end
            end
            csd_pkg::S_DIV: begin
                alu_op = csd_pkg::ALU_SUB;
                alu_a  = csd_pkg::ALU_W'(partial);
                alu_b  = csd_pkg::ALU_W'(r_snap.count);
                n_root = r_root << 1;
                n_idx  = r_idx + csd_pkg::IDX_W'(1);
                n_quo  = {r_quo[csd_pkg::QUO_W-2:0], !alu_borrow};
                if (!alu_borrow) begin
                    n_rem = csd_pkg::REM_W'(alu_result[csd_pkg::CNT_W:0]);
                end else begin
                    n_rem = csd_pkg::REM_W'(partial);
                end
                if (last_root) begin
                    n_idx = '0;
                    if (r_axis) begin
                        n_ydev = n_quo[csd_pkg::DEV_W-1:0];
                    end else begin
                        n_xdev   = n_quo[csd_pkg::DEV_W-1:0];
                        n_axis   = 1'b1;
                        n_acc    = '0;
                        n_mcand  = csd_pkg::PROD_W'(r_snap.sq_y);
                        n_mplier = csd_pkg::SUM_W'(r_snap.count);
                    end
                end
            end
            default: begin
                alu_op = csd_pkg::ALU_ADD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap   <= n_snap;
        r_axis   <= n_axis;
        r_idx    <= n_idx;
        r_acc    <= n_acc;
        r_a      <= n_a;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_v      <= n_v;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_quo    <= n_quo;
        r_xdev   <= n_xdev;
        r_ydev   <= n_ydev;
    end

    assign o_busy            = (r_state != csd_pkg::S_IDLE);
    assign o_done            = (r_state == csd_pkg::S_DONE);
    assign o_sample_count    = r_snap.count;
    assign o_x_deviation     = r_xdev;
    assign o_y_deviation     = r_ydev;
    assign o_no_samples      = (r_snap.count == '0);
    assign o_samples_dropped = r_snap.dropped;

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("Compute transfer did not start the sequencer.");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("Result strobe lasted more than one cycle.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_no_samples) |-> ((o_x_deviation == '0) && (o_y_deviation == '0)))
        else $error("Empty compute returned a nonzero deviation.");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csd_pkg::S_DIV) |-> (r_rem < csd_pkg::REM_W'(r_snap.count)))
        else $error("Divider remainder is not below the sample count.");

endmodule

// ===== src/coordinate_std_deviation_core.sv =====
// ----------------------------------------------------------------------------
// coordinate_std_deviation_core
// Accumulates position samples and reports the population standard
// deviation of x and y, with four fraction bits, on a compute request.
// ----------------------------------------------------------------------------
// A sample transfer never raises o_busy, so samples can arrive on every clock
// while o_busy is low. A compute transfer raises o_busy while one shared
// adder/subtractor runs, per axis, two shift-add products, a subtract, a
// two-bits-per-cycle square root and a restoring divide; with no samples held
// it goes straight to the result. The result appears for exactly one cycle
// with o_done, in the last busy cycle, and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module coordinate_std_deviation_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_operation,
    input  logic [csd_pkg::COORD_BITS-1:0] i_x_position,
    input  logic [csd_pkg::COORD_BITS-1:0] i_y_position,
    output logic                           o_done,
    output logic [csd_pkg::CNT_W-1:0]      o_sample_count,
    output logic [csd_pkg::DEV_W-1:0]      o_x_deviation,
    output logic [csd_pkg::DEV_W-1:0]      o_y_deviation,
    output logic                           o_no_samples,
    output logic                           o_samples_dropped
);

    csd_pkg::t_acc acc;
    logic          transfer;
    logic          add_sample;
    logic          compute;

    assign transfer   = i_start && !o_busy;
    assign add_sample = transfer && !i_operation;
    assign compute    = transfer && i_operation;

    csd_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_add   (add_sample),
        .i_clear (compute),
        .i_x     (i_x_position),
        .i_y     (i_y_position),
        .o_acc   (acc)
    );

    csd_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (compute),
        .i_acc             (acc),
        .o_busy            (o_busy),
        .o_done            (o_done),
        .o_sample_count    (o_sample_count),
        .o_x_deviation     (o_x_deviation),
        .o_y_deviation     (o_y_deviation),
        .o_no_samples      (o_no_samples),
        .o_samples_dropped (o_samples_dropped)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives position samples and compute requests into the coordinate deviation
// core and checks every reported count, deviation and flag against a
// predictor that keeps its own running sums and works out the deviations
// with exact integer arithmetic.
// ----------------------------------------------------------------------------
module testbench;

    import csd_pkg::*;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_COMPUTE = 1'b1
    } t_request;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic [DEV_W-1:0] x_dev;
        logic [DEV_W-1:0] y_dev;
        logic             empty;
        logic             dropped;
    } t_stats;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 200;
    localparam int unsigned COORD_MAX      = (1 << COORD_BITS) - 1;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_start      = 1'b0;
    logic                  i_operation  = OP_SAMPLE;
    logic [COORD_BITS-1:0] i_x_position = '0;
    logic [COORD_BITS-1:0] i_y_position = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [CNT_W-1:0]      o_sample_count;
    logic [DEV_W-1:0]      o_x_deviation;
    logic [DEV_W-1:0]      o_y_deviation;
    logic                  o_no_samples;
    logic                  o_samples_dropped;

    logic [CNT_W-1:0] acc_count   = '0;
    logic [SUM_W-1:0] acc_sum_x   = '0;
    logic [SUM_W-1:0] acc_sum_y   = '0;
    logic [SQ_W-1:0]  acc_sq_x    = '0;
    logic [SQ_W-1:0]  acc_sq_y    = '0;
    logic             acc_dropped = 1'b0;

    t_stats      pending_stats[$];
    int unsigned error_count     = 0;
    int unsigned samples_taken   = 0;
    int unsigned computes_taken  = 0;
    int unsigned results_seen    = 0;
    int unsigned empty_reports   = 0;
    int unsigned dropped_reports = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned idle_pct        = 18;

    coordinate_std_deviation_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_operation       (i_operation),
        .i_x_position      (i_x_position),
        .i_y_position      (i_y_position),
        .o_done            (o_done),
        .o_sample_count    (o_sample_count),
        .o_x_deviation     (o_x_deviation),
        .o_y_deviation     (o_y_deviation),
        .o_no_samples      (o_no_samples),
        .o_samples_dropped (o_samples_dropped)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [DEV_W-1:0] axis_deviation(longint unsigned n,
                                                        longint unsigned s,
                                                        longint unsigned sq);
        longint unsigned spread;
        longint unsigned scaled;
        longint unsigned root;
        longint unsigned trial;
        spread = (n * sq > s * s) ? n * sq - s * s : 0;
        scaled = spread << 8;
        root   = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= scaled) begin
                root = trial;
            end
        end
        return DEV_W'(root / n);
    endfunction

    function automatic t_stats predict_statistics();
        t_stats st;
        st.dropped = acc_dropped;
        if (acc_count == 0) begin
            st.count = '0;
            st.x_dev = '0;
            st.y_dev = '0;
            st.empty = 1'b1;
        end else begin
            st.count = acc_count;
            st.x_dev = axis_deviation(acc_count, acc_sum_x, acc_sq_x);
            st.y_dev = axis_deviation(acc_count, acc_sum_y, acc_sq_y);
            st.empty = 1'b0;
        end
        return st;
    endfunction

    task automatic accumulate_sample(input logic [COORD_BITS-1:0] x,
                                     input logic [COORD_BITS-1:0] y);
        if (acc_count >= MAX_SAMPLES) begin
            acc_dropped = 1'b1;
        end else begin
            acc_count = acc_count + 1'b1;
            acc_sum_x = acc_sum_x + SUM_W'(x);
            acc_sum_y = acc_sum_y + SUM_W'(y);
            acc_sq_x  = acc_sq_x + SQ_W'(x) * SQ_W'(x);
            acc_sq_y  = acc_sq_y + SQ_W'(y) * SQ_W'(y);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned expected,
                               input longint unsigned actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
            error_count++;
        end
    endtask

    // Results are checked before transfers are predicted; both use the values
    // from before the edge, so the order against the core does not matter.
    always @(posedge i_clk) begin
        t_stats st;
        quiet_cycles++;
        if (i_rst_n && o_done) begin
            quiet_cycles = 0;
            results_seen++;
            if (pending_stats.size() == 0) begin
                $display("%0t: result with no compute request outstanding", $time);
                error_count++;
            end else begin
                st = pending_stats.pop_front();
                check_field("sample_count", st.count, o_sample_count);
                check_field("x_deviation", st.x_dev, o_x_deviation);
                check_field("y_deviation", st.y_dev, o_y_deviation);
                check_field("no_samples", st.empty, o_no_samples);
                check_field("samples_dropped", st.dropped, o_samples_dropped);
                empty_reports   += st.empty;
                dropped_reports += st.dropped;
            end
        end
        if (i_rst_n && i_start && !o_busy) begin
            quiet_cycles = 0;
            if (i_operation == OP_SAMPLE) begin
                samples_taken++;
                accumulate_sample(i_x_position, i_y_position);
            end else begin
                computes_taken++;
                pending_stats.insert(pending_stats.size(), predict_statistics());
                acc_count   = '0;
                acc_sum_x   = '0;
                acc_sum_y   = '0;
                acc_sq_x    = '0;
                acc_sq_y    = '0;
                acc_dropped = 1'b0;
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input t_request op, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_start      <= 1'b1;
        i_operation  <= op;
        i_x_position <= x;
        i_y_position <= y;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_position();
        case ($urandom_range(7))
            0:       return '0;
            1:       return COORD_BITS'(COORD_MAX);
            default: return COORD_BITS'($urandom_range(COORD_MAX));
        endcase
    endfunction

    task automatic test_empty_request();
        send_item(OP_COMPUTE, '0, '0);
        send_item(OP_COMPUTE, COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX));
        drain_results();
    endtask

    task automatic test_extreme_positions();
        send_item(OP_SAMPLE, '0, '0);
        send_item(OP_COMPUTE, '0, '0);
        send_item(OP_SAMPLE, COORD_BITS'(COORD_MAX), '0);
        send_item(OP_SAMPLE, '0, COORD_BITS'(COORD_MAX));
        send_item(OP_COMPUTE, '0, '0);
        repeat (3) send_item(OP_SAMPLE, COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX));
        send_item(OP_COMPUTE, '0, '0);
        send_item(OP_SAMPLE, 12'hAAA, 12'h555);
        send_item(OP_SAMPLE, 12'h555, 12'hAAA);
        send_item(OP_SAMPLE, 12'hFFF, 12'h000);
        send_item(OP_SAMPLE, 12'h001, 12'h800);
        send_item(OP_COMPUTE, 12'h555, 12'hAAA);
        drain_results();
    endtask

    // Alternating extremes on both axes give the widest deviation that the
    // core can report.
    task automatic test_widest_spread();
        idle_pct = 0;
        for (int i = 0; i < 64; i++) begin
            send_item(OP_SAMPLE, (i % 2) ? COORD_BITS'(COORD_MAX) : '0,
                      (i % 2) ? '0 : COORD_BITS'(COORD_MAX));
        end
        send_item(OP_COMPUTE, '0, '0);
        idle_pct = 18;
        drain_results();
    endtask

    task automatic test_random_batches();
        int unsigned items_sent;
        int unsigned batch;
        bit          fixed_point;
        logic [COORD_BITS-1:0] base_x;
        logic [COORD_BITS-1:0] base_y;
        items_sent = 0;
        while (items_sent < 370) begin
            idle_pct    = (items_sent >= 150 && items_sent < 270) ? 0 : 18;
            batch       = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
            fixed_point = ($urandom_range(7) == 0);
            base_x      = pick_position();
            base_y      = pick_position();
            repeat (batch) begin
                if (fixed_point) begin
                    send_item(OP_SAMPLE, base_x, base_y);
                end else begin
                    send_item(OP_SAMPLE, pick_position(), pick_position());
                end
            end
            send_item(OP_COMPUTE, pick_position(), pick_position());
            items_sent += batch + 1;
            if ($urandom_range(15) == 0) begin
                drain_results();
            end
        end
        idle_pct = 18;
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_request();
        test_extreme_positions();
        test_widest_spread();
        test_random_batches();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_stats.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_stats.size());
            error_count++;
        end
        $display("Covered %0d sample and %0d compute transfers, %0d results checked",
                 samples_taken, computes_taken, results_seen);
        $display("of which %0d reported no samples and %0d reported dropped samples.",
                 empty_reports, dropped_reports);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
